// ----- rtl/mcar_pkg.sv -----
`timescale 1ns / 1ps

package mcar_pkg;

  localparam int MAX_ROWS = 256;

  localparam int ROW_W   = 8;
  localparam int SIZE_W  = 9;
  localparam int DELAY_W = 8;
  localparam int IDX_W   = 3;
  localparam int CFG_W   = 9;
  localparam int STICK_W = 9;
  localparam int PAD_W   = 2;

  // signed width wide enough for row, scroll and list arithmetic
  localparam int CALC_W = 11;

  typedef enum logic [PAD_W-1:0] {
    DIR_NONE = 2'b00,
    DIR_UP   = 2'b01,
    DIR_DOWN = 2'b11
  } dir_t;

  typedef enum logic [IDX_W-1:0] {
    CFG_FIRST_ROW   = 3'd0,
    CFG_LAST_ROW    = 3'd1,
    CFG_ROW_COUNT   = 3'd2,
    CFG_WINDOW_ROWS = 3'd3,
    CFG_FIRST_DELAY = 3'd4,
    CFG_NEXT_DELAY  = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [ROW_W-1:0]   first_row;
    logic [ROW_W-1:0]   last_row;
    logic [SIZE_W-1:0]  row_count;
    logic [SIZE_W-1:0]  window_rows;
    logic [DELAY_W-1:0] first_delay;
    logic [DELAY_W-1:0] next_delay;
  } cfg_t;

  typedef struct packed {
    logic fire;
    dir_t dir;
  } step_t;

endpackage

// ----- rtl/mcar_if.sv -----
`timescale 1ns / 1ps

interface mcar_pad_if;
  import mcar_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [PAD_W-1:0]   dpad_dir;
  logic signed [STICK_W-1:0] stick_pos;

  modport source (output valid, output dpad_dir, output stick_pos, input ready);
  modport sink (input valid, input dpad_dir, input stick_pos, output ready);
endinterface

interface mcar_view_if;
  import mcar_pkg::*;

  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] cursor_row;
  logic [ROW_W-1:0] scroll_top;
  logic             moved;

  modport source (output valid, output cursor_row, output scroll_top, output moved,
                  input ready);
  modport sink (input valid, input cursor_row, input scroll_top, input moved,
                output ready);
endinterface

// ----- rtl/menu_cursor_auto_repeat.sv -----
`timescale 1ns / 1ps

// Menu cursor with typematic auto-repeat. Each word on pad is one controller
// sample (d-pad wins over the analog stick, which counts at +/-128 and
// beyond); each produces exactly one word on view with the cursor row, the
// scroll top and a moved flag. A held direction moves once at once, then after
// first_delay samples, then every next_delay samples. The block takes one
// sample per clock while view is ready: a sample is held in the input
// register, then the repeat timer, row clamp and scroll window logic load
// the output register. Configuration writes on cfg_we/cfg_index/cfg_data
// are for idle time.
module menu_cursor_auto_repeat (
  input  logic                          clk,
  input  logic                          rst,
  mcar_pad_if.sink                      pad,
  mcar_view_if.source                   view,
  input  logic                          cfg_we,
  input  logic [mcar_pkg::IDX_W-1:0]    cfg_index,
  input  logic [mcar_pkg::CFG_W-1:0]    cfg_data
);
  import mcar_pkg::*;

  cfg_t cfg;

  logic                      in_v;
  logic signed [PAD_W-1:0]   dpad_q;
  logic signed [STICK_W-1:0] stick_q;
  logic                      advance;

  logic             out_v;
  logic [ROW_W-1:0] out_row;
  logic [ROW_W-1:0] out_scroll;
  logic             out_moved;

  step_t            step;
  logic [ROW_W-1:0] row_c;
  logic [ROW_W-1:0] scroll_c;
  logic             moved_c;

  assign advance   = in_v && (!out_v || view.ready);
  assign pad.ready = !in_v || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.first_row   <= ROW_W'(0);
      cfg.last_row    <= ROW_W'(7);
      cfg.row_count   <= SIZE_W'(8);
      cfg.window_rows <= SIZE_W'(7);
      cfg.first_delay <= DELAY_W'(20);
      cfg.next_delay  <= DELAY_W'(5);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FIRST_ROW:   cfg.first_row   <= cfg_data[ROW_W-1:0];
        CFG_LAST_ROW:    cfg.last_row    <= cfg_data[ROW_W-1:0];
        CFG_ROW_COUNT:   cfg.row_count   <= cfg_data[SIZE_W-1:0];
        CFG_WINDOW_ROWS: cfg.window_rows <= cfg_data[SIZE_W-1:0];
        CFG_FIRST_DELAY: cfg.first_delay <= cfg_data[DELAY_W-1:0];
        CFG_NEXT_DELAY:  cfg.next_delay  <= cfg_data[DELAY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (pad.ready) begin
      in_v <= pad.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pad.valid && pad.ready) begin
      dpad_q  <= pad.dpad_dir;
      stick_q <= pad.stick_pos;
    end
  end

  mcar_repeat u_repeat (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .dpad_dir  (dpad_q),
    .stick_pos (stick_q),
    .cfg       (cfg),
    .step      (step)
  );

  mcar_cursor u_cursor (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .step       (step),
    .cfg        (cfg),
    .cursor_row (row_c),
    .scroll_top (scroll_c),
    .moved      (moved_c)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (advance) begin
      out_v <= 1'b1;
    end else if (view.ready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_row    <= row_c;
      out_scroll <= scroll_c;
      out_moved  <= moved_c;
    end
  end

  assign view.valid      = out_v;
  assign view.cursor_row = out_row;
  assign view.scroll_top = out_scroll;
  assign view.moved      = out_moved;

endmodule

// ----- rtl/mcar_repeat.sv -----
`timescale 1ns / 1ps

module mcar_repeat (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               advance,
  input  logic signed [mcar_pkg::PAD_W-1:0]   dpad_dir,
  input  logic signed [mcar_pkg::STICK_W-1:0] stick_pos,
  input  mcar_pkg::cfg_t                     cfg,
  output mcar_pkg::step_t                    step
);
  import mcar_pkg::*;

  dir_t               held_dir;
  dir_t               held_dir_next;
  logic [DELAY_W-1:0] repeat_count;
  logic [DELAY_W-1:0] repeat_count_next;
  dir_t               dir;
  logic [DELAY_W-1:0] count_dec;
  logic               fire;

  always_comb begin
    if (dpad_dir != '0) begin
      dir = dpad_dir[PAD_W-1] ? DIR_DOWN : DIR_UP;
    end else if (stick_pos >= 9'sd128) begin
      dir = DIR_UP;
    end else if (stick_pos <= -9'sd128) begin
      dir = DIR_DOWN;
    end else begin
      dir = DIR_NONE;
    end
  end

  always_comb begin
    held_dir_next     = held_dir;
    repeat_count_next = repeat_count;
    fire              = 1'b0;
    count_dec         = (repeat_count != '0) ? repeat_count - DELAY_W'(1) : '0;
    if (dir == DIR_NONE) begin
      held_dir_next     = DIR_NONE;
      repeat_count_next = '0;
    end else if (dir != held_dir) begin
      fire              = 1'b1;
      repeat_count_next = cfg.first_delay;
      held_dir_next     = dir;
    end else if (count_dec == '0) begin
      fire              = 1'b1;
      repeat_count_next = cfg.next_delay;
    end else begin
      repeat_count_next = count_dec;
    end
  end

  assign step.fire = fire;
  assign step.dir  = dir;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_dir     <= DIR_NONE;
      repeat_count <= '0;
    end else if (advance) begin
      held_dir     <= held_dir_next;
      repeat_count <= repeat_count_next;
    end
  end

endmodule

// ----- rtl/mcar_cursor.sv -----
`timescale 1ns / 1ps

module mcar_cursor (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       advance,
  input  mcar_pkg::step_t            step,
  input  mcar_pkg::cfg_t             cfg,
  output logic [mcar_pkg::ROW_W-1:0] cursor_row,
  output logic [mcar_pkg::ROW_W-1:0] scroll_top,
  output logic                       moved
);
  import mcar_pkg::*;

  localparam logic signed [CALC_W-1:0] MaxRowsS = CALC_W'(MAX_ROWS);
  localparam logic signed [CALC_W-1:0] ScrollMax = CALC_W'((1 << ROW_W) - 1);

  logic [ROW_W-1:0] row_reg;
  logic [ROW_W-1:0] row_reg_next;
  logic [ROW_W-1:0] scroll_reg;
  logic [ROW_W-1:0] scroll_reg_next;

  logic signed [CALC_W-1:0] cand;
  logic signed [CALC_W-1:0] lo;
  logic signed [CALC_W-1:0] hi;
  logic signed [CALC_W-1:0] r;
  logic signed [CALC_W-1:0] s;
  logic signed [CALC_W-1:0] total;
  logic signed [CALC_W-1:0] vis;
  logic signed [CALC_W-1:0] top;

  always_comb begin
    lo   = {{(CALC_W-ROW_W){1'b0}}, cfg.first_row};
    hi   = {{(CALC_W-ROW_W){1'b0}}, cfg.last_row};
    cand = {{(CALC_W-ROW_W){1'b0}}, row_reg};
    if (step.dir == DIR_UP) begin
      cand = cand - CALC_W'(1);
    end else begin
      cand = cand + CALC_W'(1);
    end
    if (cand < lo) begin
      cand = lo;
    end
    if (cand > hi) begin
      cand = hi;
    end
    row_reg_next = step.fire ? cand[ROW_W-1:0] : row_reg;
    moved        = step.fire && (cand[ROW_W-1:0] != row_reg);
  end

  always_comb begin
    r     = {{(CALC_W-ROW_W){1'b0}}, row_reg_next};
    s     = {{(CALC_W-ROW_W){1'b0}}, scroll_reg};
    total = {{(CALC_W-SIZE_W){1'b0}}, cfg.row_count};
    vis   = {{(CALC_W-SIZE_W){1'b0}}, cfg.window_rows};
    if (total > MaxRowsS) begin
      total = MaxRowsS;
    end
    if (vis > MaxRowsS) begin
      vis = MaxRowsS;
    end
    if (vis < CALC_W'(1)) begin
      vis = CALC_W'(1);
    end
    if (r < s) begin
      s = r;
    end
    if (r >= s + vis) begin
      s = r - (vis - CALC_W'(1));
    end
    top = total - vis;
    if (top < 0) begin
      top = '0;
    end
    if (s < 0) begin
      s = '0;
    end
    if (s > top) begin
      s = top;
    end
    if (s > ScrollMax) begin
      s = ScrollMax;
    end
    scroll_reg_next = s[ROW_W-1:0];
  end

  assign cursor_row = row_reg_next;
  assign scroll_top = scroll_reg_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_reg    <= '0;
      scroll_reg <= '0;
    end else if (advance) begin
      row_reg    <= row_reg_next;
      scroll_reg <= scroll_reg_next;
    end
  end

endmodule

// ----- rtl/mcar_checker.sv -----
`timescale 1ns / 1ps

module mcar_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       pad_ready,
  input logic                       view_valid,
  input logic                       view_ready,
  input logic [mcar_pkg::ROW_W-1:0] cursor_row,
  input logic [mcar_pkg::ROW_W-1:0] scroll_top,
  input logic                       moved
);
  import mcar_pkg::*;

  // drop to empty after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !view_valid)
    else $error("view valid after reset");

  // hold a stalled result word
  a_view_hold: assert property (@(posedge clk) disable iff (rst)
    view_valid && !view_ready |=>
      view_valid && $stable(cursor_row) && $stable(scroll_top) && $stable(moved))
    else $error("stalled view word changed");

  // pad backs up only behind a stalled view word
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !pad_ready |-> view_valid && !view_ready)
    else $error("pad not ready without output stall");

  // the selected row never sits above the window
  a_row_visible: assert property (@(posedge clk) disable iff (rst)
    view_valid |-> scroll_top <= cursor_row)
    else $error("scroll top past cursor row");

endmodule

bind menu_cursor_auto_repeat mcar_checker u_mcar_checker (
  .clk        (clk),
  .rst        (rst),
  .pad_ready  (pad.ready),
  .view_valid (view.valid),
  .view_ready (view.ready),
  .cursor_row (view.cursor_row),
  .scroll_top (view.scroll_top),
  .moved      (view.moved)
);

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

import mcar_pkg::*;

typedef struct packed {
  logic [ROW_W-1:0] row;
  logic [ROW_W-1:0] scroll;
  logic             moved;
} view_word_t;

class cursor_tracker;
  logic [ROW_W-1:0]   first_row;
  logic [ROW_W-1:0]   last_row;
  logic [SIZE_W-1:0]  row_count;
  logic [SIZE_W-1:0]  window_rows;
  logic [DELAY_W-1:0] first_delay;
  logic [DELAY_W-1:0] next_delay;

  logic [ROW_W-1:0]   row_q;
  logic [ROW_W-1:0]   scroll_q;
  logic [DELAY_W-1:0] repeat_left;
  dir_t               held;

  view_word_t expected_views[$];
  int errors;
  int pads_seen;
  int views_seen;
  int moves_seen;

  function new();
    first_row   = 8'd0;
    last_row    = 8'd7;
    row_count   = 9'd8;
    window_rows = 9'd7;
    first_delay = 8'd20;
    next_delay  = 8'd5;
    row_q       = '0;
    scroll_q    = '0;
    repeat_left = '0;
    held        = DIR_NONE;
    errors      = 0;
    pads_seen   = 0;
    views_seen  = 0;
    moves_seen  = 0;
  endfunction

  function int pending();
    return expected_views.size();
  endfunction

  function void set_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
    case (idx)
      CFG_FIRST_ROW:   first_row   = val[ROW_W-1:0];
      CFG_LAST_ROW:    last_row    = val[ROW_W-1:0];
      CFG_ROW_COUNT:   row_count   = val[SIZE_W-1:0];
      CFG_WINDOW_ROWS: window_rows = val[SIZE_W-1:0];
      CFG_FIRST_DELAY: first_delay = val[DELAY_W-1:0];
      CFG_NEXT_DELAY:  next_delay  = val[DELAY_W-1:0];
      default: ;
    endcase
  endfunction

  function dir_t pad_dir(logic [PAD_W-1:0] dpad, logic signed [STICK_W-1:0] stick);
    if (dpad != DIR_NONE) return dpad[PAD_W-1] ? DIR_DOWN : DIR_UP;
    if (stick >= 128) return DIR_UP;
    if (stick <= -128) return DIR_DOWN;
    return DIR_NONE;
  endfunction

  function void note_pad(logic [PAD_W-1:0] dpad, logic signed [STICK_W-1:0] stick);
    dir_t d;
    bit fire;
    int next_row;
    int total;
    int vis;
    int top;
    int scr;
    int r;
    view_word_t w;
    d = pad_dir(dpad, stick);
    fire = 1'b0;
    if (d == DIR_NONE) begin
      held = DIR_NONE;
      repeat_left = '0;
    end else if (d != held) begin
      fire = 1'b1;
      repeat_left = first_delay;
      held = d;
    end else begin
      if (repeat_left > 0) repeat_left = repeat_left - 1'b1;
      if (repeat_left == 0) begin
        fire = 1'b1;
        repeat_left = next_delay;
      end
    end
    w.moved = 1'b0;
    if (fire) begin
      // up lowers the row
      next_row = int'(row_q) + ((d == DIR_UP) ? -1 : 1);
      if (next_row < int'(first_row)) next_row = int'(first_row);
      if (next_row > int'(last_row)) next_row = int'(last_row);
      if (next_row != int'(row_q)) begin
        row_q = next_row[ROW_W-1:0];
        w.moved = 1'b1;
      end
    end
    total = (row_count > MAX_ROWS) ? MAX_ROWS : int'(row_count);
    vis = (window_rows > MAX_ROWS) ? MAX_ROWS : int'(window_rows);
    if (vis < 1) vis = 1;
    scr = int'(scroll_q);
    r = int'(row_q);
    if (r < scr) scr = r;
    if (r >= scr + vis) scr = r - (vis - 1);
    top = total - vis;
    if (top < 0) top = 0;
    if (scr < 0) scr = 0;
    if (scr > top) scr = top;
    if (scr > 255) scr = 255;
    scroll_q = scr[ROW_W-1:0];
    w.row = row_q;
    w.scroll = scroll_q;
    expected_views.push_back(w);
    pads_seen++;
  endfunction

  function void check_view(logic [ROW_W-1:0] row, logic [ROW_W-1:0] scroll, logic moved);
    view_word_t w;
    views_seen++;
    if (moved === 1'b1) moves_seen++;
    if (expected_views.size() == 0) begin
      $display("%0t: unexpected view word row %0d scroll %0d moved %0d",
               $time, row, scroll, moved);
      errors++;
      return;
    end
    w = expected_views.pop_front();
    if (row !== w.row) begin
      $display("%0t: cursor_row expected %0d actual %0d", $time, w.row, row);
      errors++;
    end
    if (scroll !== w.scroll) begin
      $display("%0t: scroll_top expected %0d actual %0d", $time, w.scroll, scroll);
      errors++;
    end
    if (moved !== w.moved) begin
      $display("%0t: moved expected %0d actual %0d", $time, w.moved, moved);
      errors++;
    end
  endfunction
endclass

module tb_top;
  localparam logic [PAD_W-1:0] PAD_DOWN_ALT = 2'b10;
  localparam int PHASES = 14;
  localparam int PHASE_WORDS = 49;
  localparam int HOLD_OFF_CYCLES = 60;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  bit tx_quiet;
  bit rx_quiet;
  bit rx_hold_req;
  int settings_used;

  mcar_pad_if pad ();
  mcar_view_if view ();

  cursor_tracker sb = new();

  menu_cursor_auto_repeat dut (
    .clk(clk),
    .rst(rst),
    .pad(pad),
    .view(view),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (view.valid && view.ready)
        sb.check_view(view.cursor_row, view.scroll_top, view.moved);
      if (pad.valid && pad.ready) sb.note_pad(pad.dpad_dir, pad.stick_pos);
    end
  end

  initial begin
    int stall;
    view.ready = 1'b0;
    @(negedge rst);
    forever begin
      stall = rx_quiet ? 0 : $urandom_range(0, 13);
      if (rx_hold_req) begin
        stall = HOLD_OFF_CYCLES;
        rx_hold_req = 1'b0;
      end
      if (stall > 0) begin
        @(negedge clk) view.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk) view.ready <= 1'b1;
      do @(posedge clk); while (!view.valid);
    end
  end

  initial begin
    #5000000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_pad(logic [PAD_W-1:0] dpad, logic [STICK_W-1:0] stick);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      @(negedge clk) pad.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    pad.valid <= 1'b1;
    pad.dpad_dir <= dpad;
    pad.stick_pos <= stick;
    do @(posedge clk); while (!pad.ready);
  endtask

  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    sb.set_reg(idx, val);
  endtask

  task automatic apply_cfg(cfg_t c);
    drain();
    repeat (4) @(posedge clk);
    write_reg(CFG_FIRST_ROW, CFG_W'(c.first_row));
    write_reg(CFG_LAST_ROW, CFG_W'(c.last_row));
    write_reg(CFG_ROW_COUNT, c.row_count);
    write_reg(CFG_WINDOW_ROWS, c.window_rows);
    write_reg(CFG_FIRST_DELAY, CFG_W'(c.first_delay));
    write_reg(CFG_NEXT_DELAY, CFG_W'(c.next_delay));
    @(negedge clk) cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic cfg_t phase_cfg(int k);
    cfg_t c;
    int hi;
    case (k)
      0: c = '{8'd0, 8'd255, 9'd256, 9'd16, 8'd3, 8'd1};
      1: c = '{8'd0, 8'd0, 9'd0, 9'd0, 8'd0, 8'd0};
      2: c = '{8'd250, 8'd255, 9'd511, 9'd0, 8'd1, 8'd0};
      3: c = '{8'd255, 8'd255, 9'd511, 9'd511, 8'd255, 8'd255};
      4: c = '{8'd200, 8'd10, 9'd300, 9'd1, 8'd2, 8'd0};
      5: c = '{8'd5, 8'd40, 9'd48, 9'd9, 8'd0, 8'd2};
      default: begin
        c.first_row = ROW_W'($urandom_range(0, 255));
        hi = int'(c.first_row) + $urandom_range(0, 40);
        if (hi > 255) hi = 255;
        c.last_row = ($urandom_range(0, 9) == 0) ? ROW_W'($urandom_range(0, 255))
                                                 : ROW_W'(hi);
        c.row_count = ($urandom_range(0, 9) == 0) ? SIZE_W'($urandom_range(257, 511))
                                                  : SIZE_W'($urandom_range(0, 256));
        c.window_rows = ($urandom_range(0, 5) == 0) ? SIZE_W'($urandom_range(0, 511))
                                                    : SIZE_W'($urandom_range(1, 24));
        c.first_delay = ($urandom_range(0, 7) == 0) ? DELAY_W'($urandom_range(0, 255))
                                                    : DELAY_W'($urandom_range(0, 6));
        c.next_delay = ($urandom_range(0, 7) == 0) ? DELAY_W'($urandom_range(0, 255))
                                                   : DELAY_W'($urandom_range(0, 3));
      end
    endcase
    return c;
  endfunction

  function automatic void encode_dir(dir_t d, output logic [PAD_W-1:0] dp,
                                     output logic [STICK_W-1:0] st);
    if (d == DIR_NONE) begin
      dp = DIR_NONE;
      st = STICK_W'(int'($urandom_range(0, 254)) - 127);
    end else if ($urandom_range(0, 1)) begin
      dp = (d == DIR_UP) ? DIR_UP : ($urandom_range(0, 1) ? DIR_DOWN : PAD_DOWN_ALT);
      st = STICK_W'($urandom);
    end else begin
      dp = DIR_NONE;
      st = (d == DIR_UP) ? STICK_W'($urandom_range(128, 255))
                         : STICK_W'(-int'($urandom_range(128, 256)));
    end
  endfunction

  task automatic run_phase(int k, int count);
    int sent;
    int len;
    int kind;
    bit noise;
    dir_t d;
    logic [PAD_W-1:0] dp;
    logic [STICK_W-1:0] st;
    sent = 0;
    tx_quiet = (k % 4 == 1) || (k % 4 == 3);
    rx_quiet = (k % 4 == 2) || (k % 4 == 3);
    while (sent < count) begin
      kind = $urandom_range(0, 9);
      noise = 1'b0;
      d = DIR_NONE;
      if (kind < 7) begin
        d = $urandom_range(0, 1) ? DIR_UP : DIR_DOWN;
        len = $urandom_range(1, 16);
      end else if (kind < 9) begin
        len = $urandom_range(1, 3);
      end else begin
        noise = 1'b1;
        len = 1;
      end
      for (int j = 0; j < len && sent < count; j++) begin
        if (noise) begin
          dp = PAD_W'($urandom);
          st = STICK_W'($urandom);
        end else begin
          encode_dir(d, dp, st);
        end
        if (sent == 10 && k % 4 == 1) rx_hold_req = 1'b1;
        if (sent == 25 && k % 6 == 0) begin
          // hold the pad side until the pipe is empty
          @(negedge clk) pad.valid <= 1'b0;
          drain();
        end
        send_pad(dp, st);
        sent++;
      end
    end
    @(negedge clk) pad.valid <= 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_FIRST_ROW;
    cfg_data = '0;
    pad.valid = 1'b0;
    pad.dpad_dir = DIR_NONE;
    pad.stick_pos = '0;
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    rx_hold_req = 1'b0;
    settings_used = 1;
    repeat (5) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    send_pad(DIR_UP, 9'sd0);
    send_pad(DIR_DOWN, 9'sd0);
    send_pad(PAD_DOWN_ALT, 9'sd0);
    send_pad(DIR_NONE, -9'sd128);
    send_pad(DIR_NONE, 9'sd127);
    send_pad(DIR_NONE, -9'sd256);
    send_pad(DIR_NONE, 9'sd0);
    send_pad(DIR_NONE, 9'sd255);
    send_pad(DIR_NONE, 9'sd128);
    send_pad(DIR_NONE, -9'sd127);
    send_pad(DIR_UP, -9'sd256);
    send_pad(DIR_DOWN, 9'sd255);
    send_pad(PAD_DOWN_ALT, 9'sd255);
    @(negedge clk) pad.valid <= 1'b0;

    for (int k = 0; k < PHASES; k++) begin
      apply_cfg(phase_cfg(k));
      run_phase(k, PHASE_WORDS);
    end

    drain();
    repeat (8) @(posedge clk);
    $display("Covered %0d pad words and %0d view words (%0d with a row move) over %0d settings",
             sb.pads_seen, sb.views_seen, sb.moves_seen, settings_used);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
